// ===== src/stb_pkg.sv =====
`default_nettype none
package stb_pkg;

  localparam int POS_BITS    = 24;
  localparam int LINE_BITS   = 20;
  localparam int KW_MAX_LEN  = 11;
  localparam int KW_IDX_BITS = $clog2(KW_MAX_LEN);
  localparam int KW_COUNT    = 4;
  localparam int MAX_TOKENS  = 3;

  typedef enum logic [3:0] {
    M_IDLE,
    M_SLASH,
    M_OPER,
    M_COMMENT,
    M_STRING,
    M_NUM_INT,
    M_NUM_DOT,
    M_NUM_FRAC,
    M_IDENT
  } scan_mode_t;

  localparam logic [4:0] K_MINUS  = 5'd0;
  localparam logic [4:0] K_PLUS   = 5'd1;
  localparam logic [4:0] K_SLASH  = 5'd2;
  localparam logic [4:0] K_STAR   = 5'd3;
  localparam logic [4:0] K_BANG   = 5'd4;
  localparam logic [4:0] K_STRING = 5'd12;
  localparam logic [4:0] K_NUMBER = 5'd13;
  localparam logic [4:0] K_IDENT  = 5'd14;
  localparam logic [4:0] K_KW0    = 5'd15;
  localparam logic [4:0] K_ERROR  = 5'd19;
  localparam logic [4:0] K_EOF    = 5'd20;

  localparam logic E_UNEXPECTED   = 1'b0;
  localparam logic E_UNTERMINATED = 1'b1;

  localparam logic [1:0] OP_BANG    = 2'd0;
  localparam logic [1:0] OP_EQ      = 2'd1;
  localparam logic [1:0] OP_LESS    = 2'd2;
  localparam logic [1:0] OP_GREATER = 2'd3;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_LESS    = 8'h3C;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_GREATER = 8'h3E;

  // keyword spellings, zero padded
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
    '{8'h53, 8'h70, 8'h61, 8'h63, 8'h65, 8'h4F, 8'h64, 8'h64, 8'h69, 8'h74, 8'h79},
    '{8'h53, 8'h74, 8'h61, 8'h72, 8'h6D, 8'h61, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h5A, 8'h69, 8'h67, 8'h67, 8'h79, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4D, 8'h61, 8'h6A, 8'h6F, 8'h72, 8'h54, 8'h6F, 8'h6D, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [4:0] KW_LEN [KW_COUNT] = '{5'd11, 5'd7, 5'd5, 5'd8};

  typedef struct packed {
    logic [4:0]           kind;
    logic                 code;
    logic [POS_BITS-1:0]  start;
    logic [POS_BITS-1:0]  len;
    logic [LINE_BITS-1:0] line;
  } tok_t;

  typedef struct packed {
    logic [1:0]                  cnt;
    tok_t [MAX_TOKENS-1:0]       tok;
  } bundle_t;

endpackage
`default_nettype wire

// ===== src/source_byte_tokenizer.sv =====
// Streaming source tokenizer, one source byte per input transfer.
// Input channel: in_valid/in_ready with in_source_byte; a zero byte ends the
//   source, emits EOF and restarts offset and line counting.
// Output channel: out_valid/out_ready, one token per transfer with kind,
//   error code, start offset, length, line and a last-of-run flag marking
//   the final token caused by one input byte (a byte causes 0 to 3 tokens).
// Throughput: one byte per cycle while the queue has room; a byte causing k
//   tokens takes k output transfers. The scanner writes a bundle of tokens
//   per token-producing byte into a two-entry queue, and the output side
//   drains one token a cycle while out_ready is high, oldest bundle first.
// in_ready drops only when both queue entries are occupied, so a stalled
//   receiver holds the current token and stops input after two bundles.
// Reset (synchronous, rst_n low): scanner idle, offset 0, line 1, queue
//   empty. No clearing pass is needed.
`default_nettype none
module source_byte_tokenizer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_source_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [4:0]                   out_token_kind,
  output logic                         out_error_code,
  output logic [stb_pkg::POS_BITS-1:0]  out_start_offset,
  output logic [stb_pkg::POS_BITS-1:0]  out_token_length,
  output logic [stb_pkg::LINE_BITS-1:0] out_line_number,
  output logic                         out_last_of_run
);
  import stb_pkg::*;

  logic    push, q_full;
  bundle_t push_data;

  stb_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_source_byte,
    .q_full, .push, .push_data
  );

  stb_back u_back (
    .clk, .rst_n, .push, .push_data, .q_full,
    .out_valid, .out_ready, .out_token_kind, .out_error_code,
    .out_start_offset, .out_token_length, .out_line_number, .out_last_of_run
  );

endmodule
`default_nettype wire

// ===== src/stb_front.sv =====
`default_nettype none
module stb_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_source_byte,
  input  logic            q_full,
  output logic            push,
  output stb_pkg::bundle_t push_data
);
  import stb_pkg::*;

  localparam logic [POS_BITS-1:0]  POS_MAX  = '1;
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

  scan_mode_t             mode_r, mode_nxt;
  logic [1:0]             pend_r, pend_nxt;
  logic [POS_BITS-1:0]    pos_r, pos_nxt;
  logic [POS_BITS-1:0]    tstart_r, tstart_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [7:0]             prefix_r [KW_MAX_LEN];

  logic                   fire;
  logic                   pw_en;
  logic [KW_IDX_BITS-1:0] pw_idx;
  tok_t [MAX_TOKENS-1:0]  toks;
  logic [1:0]             n;

  function automatic logic [POS_BITS-1:0] span(input logic [POS_BITS-1:0] e,
                                               input logic [POS_BITS-1:0] s);
    return (e > s) ? e - s : '0;
  endfunction

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  always_comb begin
    logic [7:0]          c;
    logic [POS_BITS-1:0] p_inc;
    logic [POS_BITS-1:0] wlen;
    logic [POS_BITS-1:0] dot;
    logic                digit_c;
    logic                alpha_c;
    logic                do_idle;
    logic                line_up;
    logic                restart;
    logic                hit;
    logic [4:0]          opk;
    logic [4:0]          wkind;
    c        = in_source_byte;
    p_inc    = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
    wlen     = span(pos_r, tstart_r);
    dot      = (pos_r > tstart_r) ? pos_r - 1'b1 : tstart_r;
    digit_c  = (c >= 8'h30) && (c <= 8'h39);
    alpha_c  = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
               || (c == 8'h5F);
    opk      = K_BANG + {2'b00, pend_r, 1'b0};
    wkind    = K_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      hit = (wlen == POS_BITS'(KW_LEN[k]));
      for (int i = 0; i < KW_MAX_LEN; i++) begin
        if ((5'(i) < KW_LEN[k]) && (prefix_r[i] != KW_TEXT[k][i])) hit = 1'b0;
      end
      if (hit && (wkind == K_IDENT)) wkind = K_KW0 + 5'(k);
    end
    mode_nxt   = mode_r;
    pend_nxt   = pend_r;
    tstart_nxt = tstart_r;
    do_idle    = 1'b0;
    line_up    = 1'b0;
    restart    = 1'b0;
    pw_en      = 1'b0;
    pw_idx     = wlen[KW_IDX_BITS-1:0];
    toks       = '0;
    n          = 2'd0;

    case (mode_r)
      M_SLASH: begin
        if (c == CH_SLASH) begin
          mode_nxt = M_COMMENT;
        end else begin
          toks[n] = '{K_SLASH, 1'b0, tstart_r, POS_BITS'(1), line_r};
          n = n + 1'b1;
          do_idle = 1'b1;
        end
      end
      M_OPER: begin
        if (c == CH_EQ) begin
          toks[n] = '{opk + 5'd1, 1'b0, tstart_r, span(p_inc, tstart_r), line_r};
          n = n + 1'b1;
          mode_nxt = M_IDLE;
        end else begin
          toks[n] = '{opk, 1'b0, tstart_r, POS_BITS'(1), line_r};
          n = n + 1'b1;
          do_idle = 1'b1;
        end
      end
      M_COMMENT: begin
        if (c == CH_LF) begin
          line_up  = 1'b1;
          mode_nxt = M_IDLE;
        end else if (c == CH_NUL) begin
          do_idle = 1'b1;
        end
      end
      M_STRING: begin
        if (c == CH_QUOTE) begin
          toks[n] = '{K_STRING, 1'b0, tstart_r, span(p_inc, tstart_r), line_r};
          n = n + 1'b1;
          mode_nxt = M_IDLE;
        end else if (c == CH_LF) begin
          line_up = 1'b1;
        end else if (c == CH_NUL) begin
          toks[n] = '{K_ERROR, E_UNTERMINATED, tstart_r, wlen, line_r};
          n = n + 1'b1;
          do_idle = 1'b1;
        end
      end
      M_NUM_INT: begin
        if (c == CH_DOT) begin
          mode_nxt = M_NUM_DOT;
        end else if (!digit_c) begin
          toks[n] = '{K_NUMBER, 1'b0, tstart_r, wlen, line_r};
          n = n + 1'b1;
          do_idle = 1'b1;
        end
      end
      M_NUM_DOT: begin
        if (digit_c) begin
          mode_nxt = M_NUM_FRAC;
        end else begin
          toks[n] = '{K_NUMBER, 1'b0, tstart_r, span(dot, tstart_r), line_r};
          n = n + 1'b1;
          toks[n] = '{K_ERROR, E_UNEXPECTED, dot, POS_BITS'(1), line_r};
          n = n + 1'b1;
          do_idle = 1'b1;
        end
      end
      M_NUM_FRAC: begin
        if (!digit_c) begin
          toks[n] = '{K_NUMBER, 1'b0, tstart_r, wlen, line_r};
          n = n + 1'b1;
          do_idle = 1'b1;
        end
      end
      M_IDENT: begin
        if (alpha_c || digit_c) begin
          pw_en = (wlen < POS_BITS'(KW_MAX_LEN));
        end else begin
          toks[n] = '{wkind, 1'b0, tstart_r, wlen, line_r};
          n = n + 1'b1;
          do_idle = 1'b1;
        end
      end
      default: do_idle = 1'b1;
    endcase

    if (do_idle) begin
      mode_nxt = M_IDLE;
      case (c)
        CH_SPACE, CH_CR, CH_TAB: ;
        CH_LF: line_up = 1'b1;
        CH_SLASH: begin
          tstart_nxt = pos_r;
          mode_nxt   = M_SLASH;
        end
        CH_MINUS, CH_PLUS, CH_STAR: begin
          tstart_nxt = pos_r;
          toks[n] = '{(c == CH_MINUS) ? K_MINUS : (c == CH_PLUS) ? K_PLUS : K_STAR,
                      1'b0, pos_r, POS_BITS'(1), line_r};
          n = n + 1'b1;
        end
        CH_BANG, CH_EQ, CH_LESS, CH_GREATER: begin
          tstart_nxt = pos_r;
          mode_nxt   = M_OPER;
          pend_nxt   = (c == CH_BANG) ? OP_BANG : (c == CH_EQ) ? OP_EQ :
                       (c == CH_LESS) ? OP_LESS : OP_GREATER;
        end
        CH_QUOTE: begin
          tstart_nxt = pos_r;
          mode_nxt   = M_STRING;
        end
        CH_NUL: begin
          toks[n] = '{K_EOF, 1'b0, pos_r, POS_BITS'(0), line_r};
          n = n + 1'b1;
          restart = 1'b1;
        end
        default: begin
          tstart_nxt = pos_r;
          if (alpha_c) begin
            pw_en    = 1'b1;
            pw_idx   = '0;
            mode_nxt = M_IDENT;
          end else if (digit_c) begin
            mode_nxt = M_NUM_INT;
          end else begin
            toks[n] = '{K_ERROR, E_UNEXPECTED, pos_r, POS_BITS'(1), line_r};
            n = n + 1'b1;
          end
        end
      endcase
    end

    line_nxt = (line_up && (line_r != LINE_MAX)) ? line_r + 1'b1 : line_r;
    pos_nxt  = p_inc;
    if (restart) begin
      mode_nxt   = M_IDLE;
      pend_nxt   = OP_BANG;
      pos_nxt    = '0;
      tstart_nxt = '0;
      line_nxt   = LINE_BITS'(1);
    end
  end

  assign push           = fire && (n != 2'd0);
  assign push_data.cnt  = n;
  assign push_data.tok  = toks;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      pend_r   <= OP_BANG;
      pos_r    <= '0;
      tstart_r <= '0;
      line_r   <= LINE_BITS'(1);
    end else if (fire) begin
      mode_r   <= mode_nxt;
      pend_r   <= pend_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
      line_r   <= line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && pw_en) prefix_r[pw_idx] <= in_source_byte;
  end

endmodule
`default_nettype wire

// ===== src/stb_back.sv =====
`default_nettype none
module stb_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  stb_pkg::bundle_t             push_data,
  output logic                         q_full,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [4:0]                   out_token_kind,
  output logic                         out_error_code,
  output logic [stb_pkg::POS_BITS-1:0]  out_start_offset,
  output logic [stb_pkg::POS_BITS-1:0]  out_token_length,
  output logic [stb_pkg::LINE_BITS-1:0] out_line_number,
  output logic                         out_last_of_run
);
  import stb_pkg::*;

  bundle_t    mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic [1:0] idx_r;
  bundle_t    head;
  tok_t       tok;
  logic       last, xfer, pop;

  assign head      = mem_r[rd_ptr_r];
  assign tok       = head.tok[idx_r];
  assign last      = (idx_r == head.cnt - 2'd1);
  assign out_valid = (count_r != 2'd0);
  assign xfer      = out_valid && out_ready;
  assign pop       = xfer && last;
  assign q_full    = (count_r == 2'd2);

  assign out_token_kind   = tok.kind;
  assign out_error_code   = tok.code;
  assign out_start_offset = tok.start;
  assign out_token_length = tok.len;
  assign out_line_number  = tok.line;
  assign out_last_of_run  = last;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (!push && pop) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
      idx_r    <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      if (xfer) idx_r <= last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

// ===== src/stb_checker.sv =====
`default_nettype none
module stb_sva (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  out_token_kind,
  input logic        out_error_code,
  input logic [23:0] out_token_length,
  input logic [19:0] out_line_number,
  input logic        out_last_of_run
);
  import stb_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind))
    else $error("output token changed while stalled");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == K_EOF |-> out_last_of_run && out_token_length == 24'd0)
    else $error("EOF not last or nonzero length");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code |-> out_token_kind == K_ERROR)
    else $error("error code on non-error token");

  a_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line_number != 20'd0)
    else $error("line number zero");

endmodule

bind source_byte_tokenizer stb_sva u_stb_sva (
  .clk, .rst_n, .out_valid, .out_ready, .out_token_kind, .out_error_code,
  .out_token_length, .out_line_number, .out_last_of_run
);
`default_nettype wire
